// File: rtl/ppri_pkg.sv
// ppri_pkg: shared types and constants for the partial permutation rank block.
// Used by ppri_locate, ppri_rank and partial_permutation_rank_index. No dependencies.
package ppri_pkg;

    localparam int NUM_SLOTS   = 12;
    localparam int NUM_TRACKED = 6;
    localparam int ID_W        = 4;
    localparam int SLOT_W      = 4;
    localparam int OBIT_W      = 6;
    localparam int RANK_W      = 20;
    localparam int INDEX_W     = 26;
    localparam int PIECES_W    = NUM_SLOTS * ID_W;
    localparam int WEIGHT_W    = 16;
    localparam int CNT_W       = 4;

    // Lehmer weights for pieces 0..5: falling products 11!/6! down to 6!/6!
    localparam logic [WEIGHT_W-1:0] LEHMER_WEIGHT [NUM_TRACKED] = '{
        16'd55440, 16'd5040, 16'd504, 16'd56, 16'd7, 16'd1
    };

    // Where each tracked piece sits, plus its orientation flag
    typedef struct packed {
        logic [NUM_TRACKED-1:0][SLOT_W-1:0] where;
        logic [NUM_TRACKED-1:0]             obits;
    } t_locate;

endpackage

// File: rtl/ppri_locate.sv
// ppri_locate: finds the slot of each tracked piece and gathers its orientation bit.
// Depends on ppri_pkg.
module ppri_locate (
    input  logic [ppri_pkg::PIECES_W-1:0]  i_slot_pieces,
    input  logic [ppri_pkg::NUM_SLOTS-1:0] i_slot_orientations,
    output ppri_pkg::t_locate              o_locate
);

    // Scan slots in ascending order so the highest slot holding a piece wins;
    // orientation flags of duplicates are ORed, untracked ids drop out.
    always_comb begin
        o_locate = '0;
        for (int s = 0; s < ppri_pkg::NUM_SLOTS; s++) begin
            for (int p = 0; p < ppri_pkg::NUM_TRACKED; p++) begin
                if (i_slot_pieces[s*ppri_pkg::ID_W +: ppri_pkg::ID_W]
                        == ppri_pkg::ID_W'(p)) begin
                    o_locate.where[p] = ppri_pkg::SLOT_W'(s);
                    o_locate.obits[p] = o_locate.obits[p] | i_slot_orientations[s];
                end
            end
        end
    end

endmodule

// File: rtl/ppri_rank.sv
// ppri_rank: Lehmer-code rank of the placement and the packed state index.
// Depends on ppri_pkg; fed by ppri_locate.
module ppri_rank (
    input  ppri_pkg::t_locate             i_locate,
    output logic [ppri_pkg::INDEX_W-1:0]  o_state_index
);

    function automatic logic [ppri_pkg::CNT_W-1:0] popcount(
        input logic [ppri_pkg::NUM_SLOTS-1:0] v
    );
        logic [ppri_pkg::CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < ppri_pkg::NUM_SLOTS; i++) begin
            c = c + ppri_pkg::CNT_W'(v[i]);
        end
        return c;
    endfunction

    logic [ppri_pkg::NUM_SLOTS-1:0] taken;
    logic [ppri_pkg::NUM_SLOTS-1:0] onehot;
    logic [ppri_pkg::NUM_SLOTS-1:0] below;
    logic [ppri_pkg::CNT_W-1:0]     free_below;
    logic [ppri_pkg::RANK_W-1:0]    rank;

    // Each piece counts free slots below its own, then marks its slot taken
    always_comb begin
        taken = '0;
        rank  = '0;
        onehot = '0;
        below = '0;
        free_below = '0;
        for (int p = 0; p < ppri_pkg::NUM_TRACKED; p++) begin
            onehot     = ppri_pkg::NUM_SLOTS'(1) << i_locate.where[p];
            below      = onehot - ppri_pkg::NUM_SLOTS'(1);
            free_below = popcount(below & ~taken);
            rank       = rank + ppri_pkg::RANK_W'(free_below)
                              * ppri_pkg::RANK_W'(ppri_pkg::LEHMER_WEIGHT[p]);
            taken      = taken | onehot;
        end
    end

    assign o_state_index = {rank, i_locate.obits};

endmodule

// File: rtl/partial_permutation_rank_index.sv
// partial_permutation_rank_index: ranks 6 tracked pieces over 12 slots with orientation.
// Stages: input register, then result register; the rank logic between them is the only path.
// Throughput: one request per cycle unless the output stalls and both stages are full (o_stall).
// Reset: synchronous active-low i_rst_n clears both valid flags; payload regs are not reset.
// Depends on ppri_pkg, ppri_locate and ppri_rank.
module partial_permutation_rank_index (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ppri_pkg::PIECES_W-1:0]    i_slot_pieces,
    input  logic [ppri_pkg::NUM_SLOTS-1:0]   i_slot_orientations,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ppri_pkg::INDEX_W-1:0]     o_state_index
);

    logic                            r_in_valid;
    logic [ppri_pkg::PIECES_W-1:0]   r_pieces;
    logic [ppri_pkg::NUM_SLOTS-1:0]  r_oris;
    logic                            r_out_valid;
    logic [ppri_pkg::INDEX_W-1:0]    r_index;

    logic                            out_load;
    logic                            in_load;
    logic                            n_in_valid;
    logic                            n_out_valid;
    ppri_pkg::t_locate               locate;
    logic [ppri_pkg::INDEX_W-1:0]    n_index;

    // Pipeline advance: each stage moves when the one after it has room
    assign out_load    = !r_out_valid || !i_stall;
    assign in_load     = !r_in_valid || out_load;
    assign o_stall     = !in_load;
    assign n_in_valid  = in_load ? i_valid : r_in_valid;
    assign n_out_valid = out_load ? r_in_valid : r_out_valid;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_pieces <= i_slot_pieces;
            r_oris   <= i_slot_orientations;
        end
        if (out_load) begin
            r_index <= n_index;
        end
    end

    ppri_locate u_locate (
        .i_slot_pieces       (r_pieces),
        .i_slot_orientations (r_oris),
        .o_locate            (locate)
    );

    ppri_rank u_rank (
        .i_locate      (locate),
        .o_state_index (n_index)
    );

    assign o_valid       = r_out_valid;
    assign o_state_index = r_index;

    // Stall only when both stages hold a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("stall raised with room in the pipeline");

    // An accepted request lands in the input stage
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_valid)
        else $error("accepted request lost at input stage");

    // A staged request moves to the result register when it has room
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_load) |=> o_valid)
        else $error("staged request did not reach the output");

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_state_index)))
        else $error("result changed while stalled");

    // Rank never exceeds its bound, even for inconsistent placements
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_state_index < ppri_pkg::INDEX_W'(42977856)))
        else $error("state index out of range");

endmodule
